// ----- hdl/brsw_pkg.sv -----
// Package: shared constants and types for the bilinear rotate/shift warp core.
package brsw_pkg;

    localparam int ImgWidth   = 28;
    localparam int ImgHeight  = 28;
    localparam int PixelBits  = 16;
    localparam int Depth      = ImgWidth * ImgHeight;
    localparam int AddrBits   = $clog2(Depth);
    localparam int CoordBits  = 5;
    localparam int CfgIdxBits = 2;

    localparam logic [CfgIdxBits-1:0] REG_COS     = 2'd0;
    localparam logic [CfgIdxBits-1:0] REG_SIN     = 2'd1;
    localparam logic [CfgIdxBits-1:0] REG_SHIFT_X = 2'd2;
    localparam logic [CfgIdxBits-1:0] REG_SHIFT_Y = 2'd3;

    localparam logic MODE_STORE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // centre in 8-fraction-bit units: (N-1)*128
    localparam int CenterX = (ImgWidth - 1) * 128;
    localparam int CenterY = (ImgHeight - 1) * 128;

    typedef struct packed {
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic signed [13:0] shift_x;
        logic signed [13:0] shift_y;
    } cfg_t;

    // integer sample corner plus fractions, after the rotate stage
    typedef struct packed {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic [7:0]         ax;
        logic [7:0]         ay;
    } samp_t;

endpackage

// ----- hdl/brsw_rotate.sv -----
// Rotate/shift stages: pixel coordinate to integer corner and fractions.
module brsw_rotate (
    input  logic                                aclk,
    input  logic                                en,
    input  brsw_pkg::cfg_t                      cfg,
    input  logic [brsw_pkg::CoordBits-1:0]      col,
    input  logic [brsw_pkg::CoordBits-1:0]      row,
    output brsw_pkg::samp_t                     samp
);
    logic signed [15:0] xr, yr;
    logic signed [31:0] p_cx_reg, p_sy_reg, p_sx_reg, p_cy_reg;
    logic signed [33:0] rx, ry;
    logic signed [19:0] sx, sy;

    assign xr = $signed({3'b0, col, 8'b0}) - 16'(brsw_pkg::CenterX);
    assign yr = $signed({3'b0, row, 8'b0}) - 16'(brsw_pkg::CenterY);

    always_ff @(posedge aclk) begin
        if (en) begin
            p_cx_reg <= cfg.cos_angle * xr;
            p_sy_reg <= cfg.sin_angle * yr;
            p_sx_reg <= cfg.sin_angle * xr;
            p_cy_reg <= cfg.cos_angle * yr;
        end
    end

    assign rx = 34'(p_cx_reg) + 34'(p_sy_reg);
    assign ry = 34'(p_cy_reg) - 34'(p_sx_reg);
    assign sx = 20'(rx >>> 14) + 20'(brsw_pkg::CenterX) - 20'(cfg.shift_x);
    assign sy = 20'(ry >>> 14) + 20'(brsw_pkg::CenterY) - 20'(cfg.shift_y);

    always_ff @(posedge aclk) begin
        if (en) begin
            samp.x0 <= 16'(sx >>> 8);
            samp.y0 <= 16'(sy >>> 8);
            samp.ax <= sx[7:0];
            samp.ay <= sy[7:0];
        end
    end
endmodule

// ----- hdl/brsw_store.sv -----
// Frame store: four column/row parity banks; one 2x2 neighborhood per en cycle.
module brsw_store (
    input  logic                                aclk,
    input  logic                                en,
    input  logic                                wr_en,
    input  logic [brsw_pkg::CoordBits-1:0]      wr_col,
    input  logic [brsw_pkg::CoordBits-1:0]      wr_row,
    input  logic [brsw_pkg::PixelBits-1:0]      wr_data,
    input  brsw_pkg::samp_t                     samp,
    output logic [brsw_pkg::PixelBits-1:0]      p00,
    output logic [brsw_pkg::PixelBits-1:0]      p01,
    output logic [brsw_pkg::PixelBits-1:0]      p10,
    output logic [brsw_pkg::PixelBits-1:0]      p11,
    output logic [7:0]                          ax,
    output logic [7:0]                          ay
);
    localparam int HW = (brsw_pkg::ImgWidth + 1) / 2;
    localparam int HH = (brsw_pkg::ImgHeight + 1) / 2;
    localparam int BD = HW * HH;
    localparam int BA = $clog2(BD);

    logic [brsw_pkg::PixelBits-1:0] bank [4][BD];
    logic [brsw_pkg::PixelBits-1:0] rd_reg [4];
    logic [3:0] ok_reg;
    logic xpar_reg, ypar_reg;
    logic [BA-1:0] rd_addr [4];
    logic [3:0] ok;
    logic [BA-1:0] wr_addr;
    logic [1:0] wr_bank;
    logic wa_vld_reg, wb_vld_reg;
    logic [BA-1:0] wa_addr_reg, wb_addr_reg;
    logic [1:0] wa_bank_reg, wb_bank_reg;
    logic [brsw_pkg::PixelBits-1:0] wa_data_reg, wb_data_reg;

    assign wr_addr = BA'(32'(wr_row >> 1) * HW + 32'(wr_col >> 1));
    assign wr_bank = {wr_row[0], wr_col[0]};

    // bank b holds pixels with row parity b[1], column parity b[0]
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            logic signed [16:0] cx, cy;
            cx = 17'(samp.x0) + 17'((b[0] != samp.x0[0]) ? 1 : 0);
            cy = 17'(samp.y0) + 17'((b[1] != samp.y0[0]) ? 1 : 0);
            ok[b] = (cx >= 0) && (cx < brsw_pkg::ImgWidth) &&
                    (cy >= 0) && (cy < brsw_pkg::ImgHeight);
            rd_addr[b] = ok[b] ? BA'(32'(cy[15:1]) * HW + 32'(cx[15:1])) : '0;
        end
    end

    // stores travel two stages so they land in order with the reads
    always_ff @(posedge aclk) begin
        if (en) begin
            wa_vld_reg  <= wr_en && (wr_col < brsw_pkg::ImgWidth) &&
                           (wr_row < brsw_pkg::ImgHeight);
            wa_addr_reg <= wr_addr;
            wa_bank_reg <= wr_bank;
            wa_data_reg <= wr_data;
            wb_vld_reg  <= wa_vld_reg;
            wb_addr_reg <= wa_addr_reg;
            wb_bank_reg <= wa_bank_reg;
            wb_data_reg <= wa_data_reg;
            if (wb_vld_reg)
                bank[wb_bank_reg][wb_addr_reg] <= wb_data_reg;
            for (int b = 0; b < 4; b++) rd_reg[b] <= bank[b][rd_addr[b]];
            ok_reg   <= ok;
            xpar_reg <= samp.x0[0];
            ypar_reg <= samp.y0[0];
            ax <= samp.ax;
            ay <= samp.ay;
        end
    end

    // pick corners by parity of x0/y0
    always_comb begin
        logic [1:0] b00, b01, b10, b11;
        b00 = {ypar_reg, xpar_reg};
        b01 = {ypar_reg, ~xpar_reg};
        b10 = {~ypar_reg, xpar_reg};
        b11 = {~ypar_reg, ~xpar_reg};
        p00 = ok_reg[b00] ? rd_reg[b00] : '0;
        p01 = ok_reg[b01] ? rd_reg[b01] : '0;
        p10 = ok_reg[b10] ? rd_reg[b10] : '0;
        p11 = ok_reg[b11] ? rd_reg[b11] : '0;
    end
endmodule

// ----- hdl/brsw_blend.sv -----
// Bilinear blend stages: horizontal then vertical interpolation.
module brsw_blend (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [brsw_pkg::PixelBits-1:0]      p00,
    input  logic [brsw_pkg::PixelBits-1:0]      p01,
    input  logic [brsw_pkg::PixelBits-1:0]      p10,
    input  logic [brsw_pkg::PixelBits-1:0]      p11,
    input  logic [7:0]                          ax,
    input  logic [7:0]                          ay,
    output logic [brsw_pkg::PixelBits-1:0]      pix
);
    localparam int VB = brsw_pkg::PixelBits + 9;
    logic [VB-1:0] v0_reg, v1_reg;
    logic [8:0] ay_reg;
    logic [VB+8:0] acc;

    always_ff @(posedge aclk) begin
        if (en) begin
            v0_reg <= VB'(p00) * VB'(9'd256 - {1'b0, ax}) + VB'(p01) * VB'({1'b0, ax});
            v1_reg <= VB'(p10) * VB'(9'd256 - {1'b0, ax}) + VB'(p11) * VB'({1'b0, ax});
            ay_reg <= {1'b0, ay};
        end
    end

    assign acc = (VB+9)'(v0_reg) * (VB+9)'(9'd256 - ay_reg)
               + (VB+9)'(v1_reg) * (VB+9)'(ay_reg);

    always_ff @(posedge aclk) begin
        if (en) pix <= acc[brsw_pkg::PixelBits+15:16];
    end
endmodule

// ----- hdl/bilinear_rotate_shift_warp_core.sv -----
// Top level: bilinear rotate/shift warp core with frame store and pipeline.
// Usage
//   Input beats on s_axis: tuser = mode (0 store, 1 read); tdata = col, row,
//   pixel_in from bit 0 up (26 bits, zero padded to 32). A store beat writes
//   one pixel and gives no result; a read beat gives one m_axis beat with the
//   Q0.16 interpolated pixel in tdata[15:0]. Configuration: cfg_valid/cfg_ready
//   write register cfg_index with cfg_data (0 cos, 1 sin, 2 shift_x,
//   3 shift_y); write only while idle.
// Throughput and pipeline
//   One beat per cycle while m_axis is not stalled. Five register stages:
//   products, rotate/floor, frame-store read, horizontal blend, vertical
//   blend. Stores travel two stages before landing so they stay in order
//   with reads; four parity banks give all four neighbors in the same cycle.
// Reset
//   aresetn low clears the valid bits, loads the register reset values
//   (cos = 1.0) and holds s_axis_tready and cfg_ready low. The frame store is
//   not cleared: read only after the whole frame is written.
// Stall
//   With a result waiting and m_axis_tready low the whole pipeline holds and
//   s_axis_tready drops; nothing is lost or repeated.
module bilinear_rotate_shift_warp_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // col[4:0], row[9:5], pixel_in[25:10]
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // pixel_out[15:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int Stages = 5;

    brsw_pkg::cfg_t cfg_reg;
    brsw_pkg::samp_t samp;
    logic [Stages-1:0] vld_reg;
    logic en, s_fire;
    logic [brsw_pkg::CoordBits-1:0] col, row;
    logic [brsw_pkg::PixelBits-1:0] pix_in, p00, p01, p10, p11;
    logic [7:0] ax, ay;

    assign col    = s_axis_tdata[4:0];
    assign row    = s_axis_tdata[9:5];
    assign pix_in = s_axis_tdata[25:10];

    // advance whenever the output slot is empty or being taken
    assign en            = !vld_reg[Stages-1] || m_axis_tready;
    assign s_axis_tready = en && aresetn;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = aresetn;
    assign m_axis_tvalid = vld_reg[Stages-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cos_angle <= 16'sd16384;
            cfg_reg.sin_angle <= '0;
            cfg_reg.shift_x   <= '0;
            cfg_reg.shift_y   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                brsw_pkg::REG_COS:     cfg_reg.cos_angle <= cfg_data;
                brsw_pkg::REG_SIN:     cfg_reg.sin_angle <= cfg_data;
                brsw_pkg::REG_SHIFT_X: cfg_reg.shift_x   <= cfg_data[13:0];
                brsw_pkg::REG_SHIFT_Y: cfg_reg.shift_y   <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // valid bits travel with read items only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[Stages-2:0], s_fire && (s_axis_tuser == brsw_pkg::MODE_READ)};
        end
    end

    brsw_rotate u_rot (
        .aclk(aclk), .en(en), .cfg(cfg_reg), .col(col), .row(row), .samp(samp)
    );

    brsw_store u_store (
        .aclk(aclk), .en(en),
        .wr_en(s_fire && (s_axis_tuser == brsw_pkg::MODE_STORE)),
        .wr_col(col), .wr_row(row), .wr_data(pix_in),
        .samp(samp), .p00(p00), .p01(p01), .p10(p10), .p11(p11), .ax(ax), .ay(ay)
    );

    brsw_blend u_blend (
        .aclk(aclk), .en(en), .p00(p00), .p01(p01), .p10(p10), .p11(p11),
        .ax(ax), .ay(ay), .pix(m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_no_accept_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while pipeline stalled");
    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == brsw_pkg::MODE_READ
        |=> vld_reg[0])
        else $error("read item not tracked");
`endif
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Testbench for the bilinear rotate/shift warp core: random stores, reads, config phases.
module tb;

    typedef struct packed {
        logic       mode;
        logic [4:0] col;
        logic [4:0] row;
        logic [15:0] pix;
    } beat_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [15:0] m_axis_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 0;
    logic [15:0] cfg_data = 0;

    bilinear_rotate_shift_warp_core dut (.*);

    // Predictor state: shadow frame, shadow registers
    logic [15:0]        frame_shadow [brsw_pkg::Depth];
    logic signed [15:0] rot_cos = 16384, rot_sin = 0;
    logic signed [13:0] off_x = 0, off_y = 0;

    beat_t       pending_beats [$];
    logic [15:0] expected_pixels [$];
    int          error_count = 0;
    int          hold_off = 0;      // long receiver stall, counted in cycles
    bit          in_taken = 0;      // input beat accepted at the last rising edge

    initial forever #2 aclk = ~aclk;

    task automatic report(input string what);
        error_count++;
        $display("mismatch: %s", what);
    endtask

    task automatic queue_beat(input beat_t b);
        pending_beats = {pending_beats, b};
    endtask

    function automatic longint sample_at(input longint x, input longint y);
        if (x < 0 || x >= brsw_pkg::ImgWidth || y < 0 || y >= brsw_pkg::ImgHeight) return 0;
        return frame_shadow[y * brsw_pkg::ImgWidth + x];
    endfunction

    // Rotate about centre, subtract shift, bilinear blend with zero border
    function automatic logic [15:0] warp_pixel(input longint x, input longint y);
        longint xr, yr, rx, ry, sx, sy, x0, y0, ax, ay, v0, v1;
        xr = x * 256 - brsw_pkg::CenterX;
        yr = y * 256 - brsw_pkg::CenterY;
        rx = (longint'(rot_cos) * xr + longint'(rot_sin) * yr) >>> 14;
        ry = (-longint'(rot_sin) * xr + longint'(rot_cos) * yr) >>> 14;
        sx = rx + brsw_pkg::CenterX - longint'(off_x);
        sy = ry + brsw_pkg::CenterY - longint'(off_y);
        x0 = sx >>> 8;
        y0 = sy >>> 8;
        ax = sx & 255;
        ay = sy & 255;
        v0 = sample_at(x0, y0) * (256 - ax) + sample_at(x0 + 1, y0) * ax;
        v1 = sample_at(x0, y0 + 1) * (256 - ax) + sample_at(x0 + 1, y0 + 1) * ax;
        return 16'((v0 * (256 - ay) + v1 * ay) >> 16);
    endfunction

    function automatic beat_t make_beat(input logic m, input int c, input int r,
                                        input int p);
        beat_t b;
        b.mode = m; b.col = 5'(c); b.row = 5'(r); b.pix = 16'(p);
        return b;
    endfunction

    // Driver: present queued beats at falling edges with random gaps
    int gap = 0;
    always @(negedge aclk) begin
        if (in_taken) begin
            void'(pending_beats.pop_front());
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40)
                : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        end
        if (gap > 0) begin
            gap--;
            s_axis_tvalid <= 0;
        end else if (pending_beats.size() > 0) begin
            s_axis_tvalid <= 1;
            s_axis_tuser  <= pending_beats[0].mode;
            s_axis_tdata  <= {6'd0, pending_beats[0].pix, pending_beats[0].row,
                              pending_beats[0].col};
        end else begin
            s_axis_tvalid <= 0;
        end
    end

    // Receiver: long hold-off when asked, otherwise short random stalls
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off--;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 29) == 0) ? 0
                           : ($urandom_range(0, 3) != 0);
        end
    end

    // Predict on each accepted input beat
    always @(posedge aclk) begin
        in_taken <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            if (s_axis_tuser == brsw_pkg::MODE_STORE) begin
                if (s_axis_tdata[4:0] < brsw_pkg::ImgWidth &&
                    s_axis_tdata[9:5] < brsw_pkg::ImgHeight)
                    frame_shadow[s_axis_tdata[9:5] * brsw_pkg::ImgWidth + s_axis_tdata[4:0]]
                        <= s_axis_tdata[25:10];
            end else begin
                expected_pixels = {expected_pixels,
                                   warp_pixel(s_axis_tdata[4:0], s_axis_tdata[9:5])};
            end
        end
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0)
                report($sformatf("unexpected result %h", m_axis_tdata));
            else if (m_axis_tdata !== expected_pixels[0])
                report($sformatf("pixel_out got %h want %h", m_axis_tdata,
                                 expected_pixels.pop_front()));
            else
                void'(expected_pixels.pop_front());
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            brsw_pkg::REG_COS:     rot_cos = val;
            brsw_pkg::REG_SIN:     rot_sin = val;
            brsw_pkg::REG_SHIFT_X: off_x = val[13:0];
            brsw_pkg::REG_SHIFT_Y: off_y = val[13:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        int n = 0;
        while ((pending_beats.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0)
               && n < 200000) begin
            @(posedge aclk); n++;
        end
        repeat (20) @(posedge aclk);   // stores may still be in flight
    endtask

    task automatic fill_frame();
        for (int r = 0; r < brsw_pkg::ImgHeight; r++)
            for (int c = 0; c < brsw_pkg::ImgWidth; c++)
                queue_beat(make_beat(brsw_pkg::MODE_STORE, c, r, $urandom));
    endtask

    task automatic random_phase(input int count);
        repeat (count) begin
            int k = $urandom_range(0, 9);
            if (k < 7)
                queue_beat(make_beat(brsw_pkg::MODE_READ, $urandom_range(0, 31),
                                     $urandom_range(0, 31), $urandom));
            else
                queue_beat(make_beat(brsw_pkg::MODE_STORE, $urandom_range(0, 31),
                                     $urandom_range(0, 31), $urandom));
        end
    endtask

    initial begin
        int settings [6][4] = '{
            '{16384, 0, 0, 0},
            '{-16384, 0, 7168, -7168},
            '{0, 16384, -7168, 7168},
            '{0, -16384, 8191, -8192},
            '{11585, 11585, 300, -50},
            '{-32768, 32767, 0, 0}};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // Directed: full frame with extreme corner values, reads at edges
        fill_frame();
        queue_beat(make_beat(brsw_pkg::MODE_STORE, 0, 0, 16'hffff));
        queue_beat(make_beat(brsw_pkg::MODE_STORE, 27, 27, 16'h0000));
        queue_beat(make_beat(brsw_pkg::MODE_STORE, 31, 3, 16'h1234));  // ignored
        queue_beat(make_beat(brsw_pkg::MODE_STORE, 3, 30, 16'h4321));  // ignored
        queue_beat(make_beat(brsw_pkg::MODE_READ, 0, 0, 0));
        queue_beat(make_beat(brsw_pkg::MODE_READ, 27, 27, 16'hffff));
        queue_beat(make_beat(brsw_pkg::MODE_READ, 31, 31, 0));
        queue_beat(make_beat(brsw_pkg::MODE_READ, 13, 14, 0));
        queue_beat(make_beat(brsw_pkg::MODE_READ, 28, 0, 0));
        drain();
        // Pressure: stall the receiver while reads keep arriving
        hold_off = 300;
        random_phase(80);
        drain();
        for (int s = 0; s < 6; s++) begin
            write_reg(brsw_pkg::REG_COS, 16'(settings[s][0]));
            write_reg(brsw_pkg::REG_SIN, 16'(settings[s][1]));
            write_reg(brsw_pkg::REG_SHIFT_X, 16'(settings[s][2]));
            write_reg(brsw_pkg::REG_SHIFT_Y, 16'(settings[s][3]));
            random_phase(50);
            drain();
        end
        repeat (2) begin
            write_reg(brsw_pkg::REG_COS, 16'($urandom_range(0, 32768) - 16384));
            write_reg(brsw_pkg::REG_SIN, 16'($urandom_range(0, 32768) - 16384));
            write_reg(brsw_pkg::REG_SHIFT_X, 16'($urandom_range(0, 14336) - 7168));
            write_reg(brsw_pkg::REG_SHIFT_Y, 16'($urandom_range(0, 14336) - 7168));
            random_phase(40);
            drain();
        end
        if (error_count == 0 && expected_pixels.size() == 0 && pending_beats.size() == 0)
            $display("[bilinear_rotate_shift_warp_core] OK");
        else
            $display("[bilinear_rotate_shift_warp_core] ERROR");
        $finish;
    end

    initial begin
        #4000000;
        $display("[bilinear_rotate_shift_warp_core] ERROR");
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/brsw_pkg.sv
hdl/brsw_rotate.sv
hdl/brsw_store.sv
hdl/brsw_blend.sv
hdl/bilinear_rotate_shift_warp_core.sv
tb/sv/tb.sv
